// ===== design/stfb_pkg.sv =====
// Shared types and constants of the spoken temperature frame builder.
package stfb_pkg;

    // Number of segment slots a frame can carry.
    localparam int SLOT_COUNT = 6;
    localparam int SLOT_W     = 3;

    // Configuration register indexes (paddr[3:2]).
    localparam logic [1:0] REG_COMMAND_CODE     = 2'd0;
    localparam logic [1:0] REG_TEMPERATURE_WORD = 2'd1;
    localparam logic [1:0] REG_POINT_WORD       = 2'd2;
    localparam logic [1:0] REG_TEN_WORD         = 2'd3;

    // Configuration values handed to the datapath.
    typedef struct packed {
        logic [7:0] command_code;
        logic [6:0] temperature_word;
        logic [6:0] point_word;
        logic [6:0] ten_word;
    } cfg_t;

    // Controller states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TENS,
        ST_UNITS,
        ST_FRAC,
        ST_HDR,
        ST_CMD,
        ST_LEN,
        ST_SEG,
        ST_CSUM
    } state_t;

    // Digit extraction step requested of the datapath.
    typedef enum logic [1:0] {
        DIG_NONE,
        DIG_TENS,
        DIG_UNITS,
        DIG_FRAC
    } dig_step_t;

    // Which frame byte the datapath drives this cycle.
    typedef enum logic [2:0] {
        EMIT_NONE,
        EMIT_HDR,
        EMIT_CMD,
        EMIT_LEN,
        EMIT_SEG,
        EMIT_CSUM
    } emit_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic              load;
        dig_step_t         step;
        emit_t             emit;
        logic [SLOT_W-1:0] slot;
        logic              half;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [SLOT_COUNT-1:0] seg_mask;
    } dp_status_t;

endpackage

// ===== design/stfb_regs.sv =====
// APB configuration registers of the spoken temperature frame builder.
module stfb_regs (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [3:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output stfb_pkg::cfg_t    cfg
);
    import stfb_pkg::*;

    logic [7:0] command_code_reg;
    logic [6:0] temperature_word_reg;
    logic [6:0] point_word_reg;
    logic [6:0] ten_word_reg;
    logic       wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            command_code_reg     <= 8'd27;
            temperature_word_reg <= 7'd88;
            point_word_reg       <= 7'd87;
            ten_word_reg         <= 7'd10;
        end
        else if (wr_en)
        begin
            unique case (paddr[3:2])
                REG_COMMAND_CODE:     command_code_reg     <= pwdata[7:0];
                REG_TEMPERATURE_WORD: temperature_word_reg <= pwdata[6:0];
                REG_POINT_WORD:       point_word_reg       <= pwdata[6:0];
                REG_TEN_WORD:         ten_word_reg         <= pwdata[6:0];
                default:              ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_COMMAND_CODE:     prdata = {24'd0, command_code_reg};
            REG_TEMPERATURE_WORD: prdata = {25'd0, temperature_word_reg};
            REG_POINT_WORD:       prdata = {25'd0, point_word_reg};
            REG_TEN_WORD:         prdata = {25'd0, ten_word_reg};
            default:              prdata = 32'd0;
        endcase
    end

    assign cfg.command_code     = command_code_reg;
    assign cfg.temperature_word = temperature_word_reg;
    assign cfg.point_word       = point_word_reg;
    assign cfg.ten_word         = ten_word_reg;

endmodule

// ===== design/stfb_ctrl.sv =====
// Controller state machine that sequences digit extraction and frame bytes.
module stfb_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  stfb_pkg::dp_status_t   status,
    output stfb_pkg::ctrl_cmd_t    cmd
);
    import stfb_pkg::*;

    state_t            state_reg;
    state_t            state_next;
    logic [SLOT_W-1:0] slot_reg;
    logic [SLOT_W-1:0] slot_next;
    logic              half_reg;
    logic              half_next;
    logic [SLOT_W-1:0] slot_found;
    logic              found;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            slot_reg  <= '0;
            half_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            slot_reg  <= slot_next;
            half_reg  <= half_next;
        end
    end

    // Next enabled segment slot after the current one.
    always_comb
    begin
        found      = 1'b0;
        slot_found = '0;
        for (int k = 0; k < SLOT_COUNT; k++)
        begin
            if (!found && (SLOT_W'(k) > slot_reg) && status.seg_mask[k])
            begin
                found      = 1'b1;
                slot_found = SLOT_W'(k);
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        slot_next  = slot_reg;
        half_next  = half_reg;
        cmd.load   = 1'b0;
        cmd.step   = DIG_NONE;
        cmd.emit   = EMIT_NONE;
        cmd.slot   = slot_reg;
        cmd.half   = half_reg;
        busy       = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_TENS;
                end
            end
            ST_TENS:
            begin
                cmd.step   = DIG_TENS;
                state_next = ST_UNITS;
            end
            ST_UNITS:
            begin
                cmd.step   = DIG_UNITS;
                state_next = ST_FRAC;
            end
            ST_FRAC:
            begin
                cmd.step   = DIG_FRAC;
                state_next = ST_HDR;
            end
            ST_HDR:
            begin
                cmd.emit   = EMIT_HDR;
                state_next = ST_CMD;
            end
            ST_CMD:
            begin
                cmd.emit   = EMIT_CMD;
                state_next = ST_LEN;
            end
            ST_LEN:
            begin
                cmd.emit   = EMIT_LEN;
                slot_next  = '0;
                half_next  = 1'b0;
                state_next = ST_SEG;
            end
            ST_SEG:
            begin
                cmd.emit = EMIT_SEG;
                if (!half_reg)
                begin
                    half_next = 1'b1;
                end
                else if (found)
                begin
                    half_next = 1'b0;
                    slot_next = slot_found;
                end
                else
                begin
                    state_next = ST_CSUM;
                end
            end
            ST_CSUM:
            begin
                cmd.emit   = EMIT_CSUM;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== design/stfb_dp.sv =====
// Datapath: digit extraction, segment byte selection, checksum and output register.
module stfb_dp (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [9:0]            tenths,
    input  stfb_pkg::cfg_t        cfg,
    input  stfb_pkg::ctrl_cmd_t   cmd,
    output stfb_pkg::dp_status_t  status,
    output logic                  byte_valid,
    output logic [7:0]            frame_byte,
    output logic                  last
);
    import stfb_pkg::*;

    localparam logic [9:0] MAX_TENTHS  = 10'd999;
    localparam logic [7:0] HEADER_BYTE = 8'hAA;
    localparam logic [7:0] ASCII_ZERO  = 8'h30;

    logic [9:0]  t_reg;
    logic [3:0]  tens_reg;
    logic [6:0]  rem_reg;
    logic [3:0]  units_reg;
    logic [3:0]  frac_reg;
    logic [7:0]  sum_reg;
    logic [7:0]  sum_next;
    logic        valid_reg;
    logic [7:0]  byte_reg;
    logic        last_reg;

    logic [15:0] tens_prod;
    logic [3:0]  tens_q;
    logic [9:0]  rem_wide;
    logic [14:0] units_prod;
    logic [6:0]  frac_wide;
    logic [6:0]  seg_val;
    logic [14:0] seg_prod;
    logic [3:0]  seg_hi;
    logic [6:0]  seg_lo;
    logic [3:0]  seg_digit;
    logic [2:0]  seg_cnt;
    logic [7:0]  cur_byte;

    // Division by 100 and by 10 as multiplications by a scaled reciprocal;
    // exact over the ranges that reach them.
    assign tens_prod  = 16'(t_reg) * 16'd41;
    assign tens_q     = tens_prod[15:12];
    assign rem_wide   = t_reg - 10'(tens_q) * 10'd100;
    assign units_prod = 15'(rem_reg) * 15'd205;
    assign frac_wide  = rem_reg - 7'(units_reg) * 7'd10;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            t_reg <= (tenths > MAX_TENTHS) ? MAX_TENTHS : tenths;
        end
        case (cmd.step)
            DIG_TENS:
            begin
                tens_reg <= tens_q;
                rem_reg  <= rem_wide[6:0];
            end
            DIG_UNITS: units_reg <= units_prod[14:11];
            DIG_FRAC:  frac_reg  <= frac_wide[3:0];
            default:   ;
        endcase
    end

    // Slot order: temperature word, tens digit, ten word, units (or "00"),
    // point word, tenths digit.
    always_comb
    begin
        status.seg_mask[0] = 1'b1;
        status.seg_mask[1] = (tens_reg >= 4'd2);
        status.seg_mask[2] = (tens_reg != 4'd0);
        status.seg_mask[3] = (units_reg != 4'd0) || (tens_reg == 4'd0);
        status.seg_mask[4] = 1'b1;
        status.seg_mask[5] = (frac_reg != 4'd0);
    end

    always_comb
    begin
        case (cmd.slot)
            3'd0:    seg_val = cfg.temperature_word;
            3'd1:    seg_val = {3'd0, tens_reg};
            3'd2:    seg_val = cfg.ten_word;
            3'd3:    seg_val = {3'd0, units_reg};
            3'd4:    seg_val = cfg.point_word;
            3'd5:    seg_val = {3'd0, frac_reg};
            default: seg_val = 7'd0;
        endcase
    end

    // Two ASCII digits of the segment code; the high digit may exceed nine.
    assign seg_prod  = 15'(seg_val) * 15'd205;
    assign seg_hi    = seg_prod[14:11];
    assign seg_lo    = seg_val - 7'(seg_hi) * 7'd10;
    assign seg_digit = cmd.half ? seg_lo[3:0] : seg_hi;
    assign seg_cnt   = 3'($countones(status.seg_mask));

    always_comb
    begin
        unique case (cmd.emit)
            EMIT_HDR:  cur_byte = HEADER_BYTE;
            EMIT_CMD:  cur_byte = cfg.command_code;
            EMIT_LEN:  cur_byte = {4'd0, seg_cnt, 1'b0};
            EMIT_SEG:  cur_byte = ASCII_ZERO + {4'd0, seg_digit};
            EMIT_CSUM: cur_byte = sum_reg;
            default:   cur_byte = 8'd0;
        endcase
    end

    always_comb
    begin
        sum_next = sum_reg;
        case (cmd.emit) inside
            EMIT_HDR:                     sum_next = HEADER_BYTE;
            EMIT_CMD, EMIT_LEN, EMIT_SEG: sum_next = sum_reg + cur_byte;
            default:                      sum_next = sum_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        sum_reg <= sum_next;
        if (cmd.emit != EMIT_NONE)
        begin
            byte_reg <= cur_byte;
            last_reg <= (cmd.emit == EMIT_CSUM);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= (cmd.emit != EMIT_NONE);
        end
    end

    assign byte_valid = valid_reg;
    assign frame_byte = byte_reg;
    assign last       = last_reg && valid_reg;

endmodule

// ===== design/spoken_temperature_frame_builder_core.sv =====
// Top level of the spoken temperature frame builder: registers, controller and datapath.
//
// Channel        | Direction | Signals                                  | Handshake
// ---------------+-----------+------------------------------------------+-----------------------
// temperature    | in        | start, busy, tenths                      | start && !busy
// frame bytes    | out       | byte_valid, frame_byte, last             | byte_valid strobe
// configuration  | in/out    | psel, penable, pwrite, paddr, pwdata,    | APB, pready tied high
//                |           | prdata, pready                           |
//
// A temperature item is taken when start is high while busy is low. The block
// then splits the value into tens, units and tenths digits, one
// divide-by-constant step per cycle, and afterwards sends one frame byte per
// cycle: header, command code, length, the segment digit pairs and the
// checksum. A frame has 10 to 16 bytes, and busy stays high until its checksum
// byte has been chosen, so no new item is taken before then.
// Each byte appears on the output for exactly one cycle, in the cycle after the
// controller has chosen it; the receiver cannot stall the stream. The checksum
// byte is flagged by last and is shown in the cycle in which busy has already
// dropped, so the next item may be taken while it is still on the output.
// Reset is asynchronous and active low; it returns the configuration registers
// to their defaults and the controller to idle. No clearing pass is needed.
module spoken_temperature_frame_builder_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [9:0]  tenths,
    output logic        byte_valid,
    output logic [7:0]  frame_byte,
    output logic        last,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import stfb_pkg::*;

    cfg_t       cfg;
    ctrl_cmd_t  cmd;
    dp_status_t status;
    logic       accept;

    assign accept = start && !busy;

    // Configuration registers behind the APB port.
    stfb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // The controller walks the digit steps and then the frame byte by byte,
    // skipping segment slots that the datapath reports as unused.
    stfb_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .status (status),
        .cmd    (cmd)
    );

    // The datapath holds the digits, forms each byte, keeps the running sum
    // and registers the output.
    stfb_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .tenths     (tenths),
        .cfg        (cfg),
        .cmd        (cmd),
        .status     (status),
        .byte_valid (byte_valid),
        .frame_byte (frame_byte),
        .last       (last)
    );

    // An accepted item makes the block busy in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n) accept |=> busy)
        else $error("busy did not rise after an item was accepted");

    // No byte is on the output in the cycle after an item is taken.
    assert property (@(posedge clk) disable iff (!rst_n) accept |=> !byte_valid)
        else $error("frame byte appeared during digit extraction");

    // The checksum byte is shown only once the controller is idle again.
    assert property (@(posedge clk) disable iff (!rst_n) (byte_valid && last) |-> !busy)
        else $error("checksum byte shown while the controller is still busy");

    // busy rises only because an item was taken.
    assert property (@(posedge clk) disable iff (!rst_n) $rose(busy) |-> $past(start))
        else $error("busy rose without a start request");

endmodule
